// ===== src/colp_pkg.sv =====
// Shared types, register indexes and helpers for the cell overvoltage
// protection block. No dependencies.
package colp_pkg;

  // Machine states, shared by the overvoltage and latch machines.
  // The unused fourth code is handled as idle by default arms.
  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_ALERT  = 2'd1,
    ST_TRIP   = 2'd2
  } mach_state_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ENABLES       = 3'd0,
    REG_OV_THRESHOLD  = 3'd1,
    REG_OV_TRIP_DELAY = 3'd2,
    REG_OV_REC_HYST   = 3'd3,
    REG_OV_REC_TIME   = 3'd4,
    REG_LAT_LIMIT     = 3'd5,
    REG_LAT_DECAY     = 3'd6,
    REG_LAT_REC_TIME  = 3'd7
  } reg_index_t;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned VOLT_W     = 16;
  localparam int unsigned CNT_W      = 8;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [VOLT_W-1:0] volt_t;

  typedef struct packed {
    logic [1:0] enables;
    volt_t      ov_threshold;
    cnt_t       ov_trip_delay;
    cnt_t       ov_rec_hyst;
    cnt_t       ov_rec_time;
    cnt_t       lat_limit;
    cnt_t       lat_decay;
    cnt_t       lat_rec_time;
  } prot_cfg_t;

  typedef struct packed {
    mach_state_t ov_state;
    cnt_t        ov_delay;
    cnt_t        ov_rec;
    mach_state_t lat_state;
    cnt_t        lat_trip;
    cnt_t        lat_quiet;
    cnt_t        lat_rec;
  } prot_state_t;

  typedef struct packed {
    logic ov_alert;
    logic ov_error;
    logic latch_warn;
    logic latch_error;
  } prot_flags_t;

  // Saturating increment at the counter ceiling
  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + cnt_t'(1);
  endfunction

  // count + 1 >= setting, without wrap
  function automatic logic cnt_reached(input cnt_t cnt, input cnt_t setting);
    cnt_reached = ({1'b0, cnt} + {{CNT_W{1'b0}}, 1'b1}) >= {1'b0, setting};
  endfunction

endpackage

// ===== src/colp_step.sv =====
// One end-of-scan step: overvoltage machine then latch machine.
// Pure combinational logic; uses colp_pkg.
module colp_step
  import colp_pkg::*;
(
  input  prot_cfg_t   cfg,
  input  prot_state_t cur,
  input  volt_t       scan_max,
  output prot_state_t nxt,
  output prot_flags_t flags
);

  logic  over;
  logic  above_rec;
  volt_t rec_level;
  prot_state_t mid;

  assign over      = scan_max >= cfg.ov_threshold;
  assign rec_level = (cfg.ov_threshold > {8'd0, cfg.ov_rec_hyst}) ?
                     cfg.ov_threshold - {8'd0, cfg.ov_rec_hyst} : '0;
  assign above_rec = scan_max >= rec_level;

  // flags reflect the states held before this step
  assign flags.ov_alert    = cfg.enables[0] && (cur.ov_state == ST_ALERT);
  assign flags.ov_error    = cfg.enables[0] && (cur.ov_state == ST_TRIP);
  assign flags.latch_warn  = cfg.enables[1] && (cur.lat_state == ST_ALERT);
  assign flags.latch_error = cfg.enables[1] && (cur.lat_state == ST_TRIP);

  // overvoltage machine; it also feeds the latch trip and quiet counts
  always_comb begin
    mid = cur;
    if (!cfg.enables[0]) begin
      mid.ov_state  = ST_NORMAL;
      mid.ov_delay  = '0;
      mid.ov_rec    = '0;
      mid.lat_quiet = '0;
    end else begin
      case (cur.ov_state)
        ST_ALERT: begin
          if (over && cnt_reached(cur.ov_delay, cfg.ov_trip_delay)) begin
            mid.ov_delay = '0;
            mid.ov_state = ST_TRIP;
            if (cur.lat_state != ST_TRIP) mid.lat_trip = sat_inc(cur.lat_trip);
          end else if (!over) begin
            mid.ov_delay = '0;
            mid.ov_state = ST_NORMAL;
          end else begin
            mid.ov_delay = sat_inc(cur.ov_delay);
          end
        end
        ST_TRIP: begin
          if (!above_rec) begin
            if (cnt_reached(cur.ov_rec, cfg.ov_rec_time)) begin
              mid.ov_rec    = '0;
              mid.lat_quiet = '0;
              mid.ov_state  = ST_NORMAL;
            end else begin
              mid.ov_rec = sat_inc(cur.ov_rec);
            end
          end
        end
        default: begin
          mid.ov_state = ST_NORMAL;
          if (over) begin
            mid.ov_delay = sat_inc(cur.ov_delay);
            mid.ov_state = ST_ALERT;
          end else if (cur.lat_trip != '0) begin
            mid.lat_quiet = sat_inc(cur.lat_quiet);
          end
        end
      endcase
    end
  end

  // latch machine, on the counts left by the overvoltage step
  always_comb begin
    nxt = mid;
    if (!cfg.enables[1]) begin
      nxt.lat_state = ST_NORMAL;
      nxt.lat_trip  = '0;
      nxt.lat_rec   = '0;
    end else begin
      case (mid.lat_state)
        ST_ALERT: begin
          if (mid.lat_trip == cfg.lat_limit) begin
            nxt.lat_trip  = '0;
            nxt.lat_state = ST_TRIP;
          end else if (mid.lat_trip == '0) begin
            nxt.lat_state = ST_NORMAL;
          end else if (mid.lat_quiet >= cfg.lat_decay) begin
            nxt.lat_trip = mid.lat_trip - cnt_t'(1);
          end
        end
        ST_TRIP: begin
          if (cnt_reached(mid.lat_rec, cfg.lat_rec_time)) begin
            nxt.lat_rec   = '0;
            nxt.lat_state = ST_NORMAL;
          end else begin
            nxt.lat_rec = sat_inc(mid.lat_rec);
          end
        end
        default: begin
          nxt.lat_state = (mid.lat_trip != '0) ? ST_ALERT : ST_NORMAL;
        end
      endcase
    end
  end

endmodule

// ===== src/cell_overvoltage_protect_latch_top.sv =====
// Top level of the cell overvoltage protection block with fault latch.
// Depends on colp_pkg and colp_step.
//
// Usage:
//  - in_*  : one cell voltage per item; in_last_cell = 1 closes a scan.
//  - out_* : one item per closed scan with four flags, each showing the
//            state a machine held before that scan's step.
//  - cfg_* : register writes (index, data), always ready; write only while
//            the block is idle.
// Timing: an accepted item lands in the input register; when it moves on, its
//  scan maximum is folded in and, for a last cell, the machines step and
//  the flags are loaded into the output register. Throughput is one item per
//  cycle while no last-cell item waits on a pending result; the only loop
//  is the running maximum plus one state step.
// Stall: a non-last item never needs the output, so it always moves on.
//  A last-cell item waits in the input register while a result is still
//  pending; in_ready falls only then.
// Reset (rst_n low, synchronous): valid and config registers go to their
//  defaults, both machines idle, counts and the scan maximum cleared, no items in flight.
// Scans may have any length (nominally 16 cells); only the mark matters.
module cell_overvoltage_protect_latch_top
  import colp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // cell input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VOLT_W-1:0]     in_cell_voltage,
  input  logic                  in_last_cell,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_ov_alert,
  output logic                  out_ov_error,
  output logic                  out_latch_warn,
  output logic                  out_latch_error,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  prot_cfg_t   cfg_r;
  prot_state_t st_r;
  prot_state_t st_nxt;
  prot_flags_t step_flags;
  prot_flags_t flags_r;
  volt_t       scan_max_r;
  volt_t       scan_max_nxt;

  // input register
  logic  s1_valid_r;
  volt_t s1_volt_r;
  logic  s1_last_r;
  logic  out_valid_r;

  logic out_free;
  logic s1_adv;
  logic in_acc;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enables       <= 2'd0;
      cfg_r.ov_threshold  <= {VOLT_W{1'b1}};
      cfg_r.ov_trip_delay <= cnt_t'(1);
      cfg_r.ov_rec_hyst   <= '0;
      cfg_r.ov_rec_time   <= cnt_t'(1);
      cfg_r.lat_limit     <= cnt_t'(1);
      cfg_r.lat_decay     <= '0;
      cfg_r.lat_rec_time  <= cnt_t'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_ENABLES:       cfg_r.enables       <= cfg_data[1:0];
        REG_OV_THRESHOLD:  cfg_r.ov_threshold  <= cfg_data[VOLT_W-1:0];
        REG_OV_TRIP_DELAY: cfg_r.ov_trip_delay <= cfg_data[CNT_W-1:0];
        REG_OV_REC_HYST:   cfg_r.ov_rec_hyst   <= cfg_data[CNT_W-1:0];
        REG_OV_REC_TIME:   cfg_r.ov_rec_time   <= cfg_data[CNT_W-1:0];
        REG_LAT_LIMIT:     cfg_r.lat_limit     <= cfg_data[CNT_W-1:0];
        REG_LAT_DECAY:     cfg_r.lat_decay     <= cfg_data[CNT_W-1:0];
        REG_LAT_REC_TIME:  cfg_r.lat_rec_time  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: output register frees when empty or being taken; a last
  // item needs it, any other item passes straight through.
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_volt_r <= in_cell_voltage;
      s1_last_r <= in_last_cell;
    end
  end

  // running maximum including the item now in the input register
  assign scan_max_nxt = (s1_volt_r > scan_max_r) ? s1_volt_r : scan_max_r;

  colp_step u_step (
    .cfg      (cfg_r),
    .cur      (st_r),
    .scan_max (scan_max_nxt),
    .nxt      (st_nxt),
    .flags    (step_flags)
  );

  // scan maximum and machine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_max_r    <= '0;
      st_r.ov_state <= ST_NORMAL;
      st_r.ov_delay <= '0;
      st_r.ov_rec   <= '0;
      st_r.lat_state <= ST_NORMAL;
      st_r.lat_trip  <= '0;
      st_r.lat_quiet <= '0;
      st_r.lat_rec   <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        scan_max_r <= '0;
        st_r       <= st_nxt;
      end else begin
        scan_max_r <= scan_max_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      flags_r <= step_flags;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ov_alert    = flags_r.ov_alert;
  assign out_ov_error    = flags_r.ov_error;
  assign out_latch_warn  = flags_r.latch_warn;
  assign out_latch_error = flags_r.latch_error;

endmodule
